// ----- design/iai_pkg.sv -----
// ----------------------------------------------------------------------------
// iai_pkg: shared types and constants for the indexed array block
// Capacity, derived widths, operation codes and the command broadcast to
// the row of storage cells.
// ----------------------------------------------------------------------------
package iai_pkg;

   localparam int CAPACITY  = 64;
   localparam int WORD_W    = 32;
   localparam int REQ_IDX_W = 7;
   localparam int RSP_CNT_W = 7;
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int POS_W     = $clog2(CAPACITY);
   localparam int CMP_W     = (CNT_W > REQ_IDX_W) ? CNT_W : REQ_IDX_W;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_INSERT = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef struct packed {
      logic               en;
      op_type             op;
      logic [CMP_W-1:0]   idx;
      logic [WORD_W-1:0]  value;
   } cmd_type;

endpackage

// ----- design/indexed_array_insert_remove_top.sv -----
// Latency: a request's response is registered and valid the cycle after it is accepted.
// Throughput: one request per cycle; the whole row of cells shifts in that single cycle.
// A new request is accepted while a response waits only if that response is taken too.
// Reset: synchronous, active high; clears the fill count and the response valid.
// Stored words are not cleared; slots at or above the count are never observed.
// ----------------------------------------------------------------------------
// indexed_array_insert_remove_top: ordered word list with insert and remove
// Checks each request against the fill count, drives the cell row and
// returns the read word, updated count and error flag.
// ----------------------------------------------------------------------------
module indexed_array_insert_remove_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_func,
   input  logic [iai_pkg::REQ_IDX_W-1:0]        req_index,
   input  logic signed [iai_pkg::WORD_W-1:0]    req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [iai_pkg::WORD_W-1:0]    rsp_read_value,
   output logic [iai_pkg::RSP_CNT_W-1:0]        rsp_count,
   output logic                                 rsp_error
);

   logic [iai_pkg::CNT_W-1:0]     count_ff;
   logic [iai_pkg::CNT_W-1:0]     count_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [iai_pkg::WORD_W-1:0]    rsp_read_value_ff;
   logic [iai_pkg::RSP_CNT_W-1:0] rsp_count_ff;
   logic                          rsp_error_ff;

   logic                          req_fire;
   logic                          op_ok;
   iai_pkg::op_type               op;
   iai_pkg::cmd_type              cmd;
   logic [iai_pkg::CMP_W-1:0]     idx;
   logic [iai_pkg::CMP_W-1:0]     cnt;
   logic [iai_pkg::WORD_W-1:0]    read_word;

   assign op        = iai_pkg::op_type'(req_func);
   assign idx       = iai_pkg::CMP_W'(req_index);
   assign cnt       = iai_pkg::CMP_W'(count_ff);
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      unique case (op)
         iai_pkg::OP_INSERT:
            op_ok = (idx <= cnt) && (count_ff < iai_pkg::CNT_W'(iai_pkg::CAPACITY));
         default:
            op_ok = (idx < cnt);
      endcase
   end

   always_comb begin
      cmd.en    = req_fire && op_ok;
      cmd.op    = op;
      cmd.idx   = idx;
      cmd.value = req_value;
   end

   iai_array u_array (
      .clock     (clock),
      .cmd       (cmd),
      .read_word (read_word)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.en) begin
         case (op)
            iai_pkg::OP_INSERT: count_in = count_ff + iai_pkg::CNT_W'(1);
            iai_pkg::OP_REMOVE: count_in = count_ff - iai_pkg::CNT_W'(1);
            default:            count_in = count_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_read_value_ff <= (op == iai_pkg::OP_READ && op_ok) ? read_word : '0;
         rsp_count_ff      <= iai_pkg::RSP_CNT_W'(count_in);
         rsp_error_ff      <= !op_ok;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_error      = rsp_error_ff;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= iai_pkg::CNT_W'(iai_pkg::CAPACITY))
      else $error("fill count above capacity");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      (cmd.en && op == iai_pkg::OP_INSERT) |=> count_ff == $past(count_ff) + iai_pkg::CNT_W'(1))
      else $error("insert did not grow the count");

   a_count_hold : assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_ff))
      else $error("count changed without a request");

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_error_ff) |-> rsp_read_value_ff == '0)
      else $error("refused request returned data");
`endif

endmodule

// ----- design/iai_cell.sv -----
// ----------------------------------------------------------------------------
// iai_cell: one storage slot of the list
// Holds one word; loads the request word, the left neighbor on insert or
// the right neighbor on remove, as the broadcast command selects.
// ----------------------------------------------------------------------------
module iai_cell (
   input  logic                       clock,
   input  iai_pkg::cmd_type           cmd,
   input  logic [iai_pkg::POS_W-1:0]  cell_pos,
   input  logic [iai_pkg::WORD_W-1:0] left_word,
   input  logic [iai_pkg::WORD_W-1:0] right_word,
   output logic [iai_pkg::WORD_W-1:0] word
);

   logic [iai_pkg::WORD_W-1:0] word_ff;
   logic [iai_pkg::WORD_W-1:0] word_in;
   logic [iai_pkg::CMP_W-1:0]  pos;
   logic                       at_idx;
   logic                       above_idx;

   assign pos       = iai_pkg::CMP_W'(cell_pos);
   assign at_idx    = (pos == cmd.idx);
   assign above_idx = (pos > cmd.idx);

   always_comb begin
      word_in = word_ff;
      if (cmd.en) begin
         case (cmd.op)
            iai_pkg::OP_WRITE: begin
               if (at_idx) word_in = cmd.value;
            end
            iai_pkg::OP_INSERT: begin
               if (at_idx) word_in = cmd.value;
               else if (above_idx) word_in = left_word;
            end
            iai_pkg::OP_REMOVE: begin
               if (at_idx || above_idx) word_in = right_word;
            end
            default: word_in = word_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ----- design/iai_array.sv -----
// ----------------------------------------------------------------------------
// iai_array: row of storage cells with read select
// Chains the cells so each hands its word to every neighbor it has, feeding zero in
// at both ends, and selects the word at the requested position for reads.
// ----------------------------------------------------------------------------
module iai_array (
   input  logic                       clock,
   input  iai_pkg::cmd_type           cmd,
   output logic [iai_pkg::WORD_W-1:0] read_word
);

   logic [iai_pkg::WORD_W-1:0] words [iai_pkg::CAPACITY];

   for (genvar i = 0; i < iai_pkg::CAPACITY; i++) begin : g_cell
      logic [iai_pkg::WORD_W-1:0] left_w;
      logic [iai_pkg::WORD_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = words[i-1];
      end

      if (i == iai_pkg::CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = words[i+1];
      end

      iai_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_pos   (iai_pkg::POS_W'(i)),
         .left_word  (left_w),
         .right_word (right_w),
         .word       (words[i])
      );
   end

   assign read_word = words[cmd.idx[iai_pkg::POS_W-1:0]];

endmodule
